// ===== hdl/hncr_pkg.sv =====
// Package for the held-note chord recognizer: word types, voicing tables,
// chord class table and sequencer states. No dependencies.
`default_nettype none
package hncr_pkg;

	localparam int MaxHeld = 5;
	localparam int NumTypes = 22;
	localparam int NumVoicings = 7;

	typedef struct packed {
		logic       kind;
		logic [6:0] note;
		logic [6:0] velocity;
	} in_word_t;

	typedef struct packed {
		logic [2:0] held_count;
		logic       matched;
		logic [3:0] root;
		logic [3:0] bass;
		logic [4:0] chord_type;
		logic [1:0] chord_class;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_DETECT,
		ST_DONE
	} state_t;

	// one voicing: note count, five held indices, raise mask (bit i adds 12 to slot i)
	typedef struct packed {
		logic [2:0]      cnt;
		logic [4:0][2:0] idx;
		logic [4:0]      raise;
	} voicing_t;

	localparam logic KIND_NOTE   = 1'b0;
	localparam logic KIND_DETECT = 1'b1;

	function automatic voicing_t mk(input logic [2:0] c, input logic [2:0] a0,
			input logic [2:0] a1, input logic [2:0] a2, input logic [2:0] a3,
			input logic [2:0] a4, input logic [4:0] r);
		voicing_t v;
		v.cnt = c;
		v.idx = {a4, a3, a2, a1, a0};
		v.raise = r;
		return v;
	endfunction

	// raise mask written with slot 0 as bit 0
	function automatic voicing_t voicing(input logic [2:0] total, input logic [2:0] k);
		voicing_t v;
		v = mk(3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 5'b00000);
		unique case (total)
			3'd5: begin
				unique case (k)
					3'd0: v = mk(3'd5, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 5'b00000);
					3'd1: v = mk(3'd4, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 5'b00000);
					3'd2: v = mk(3'd4, 3'd2, 3'd3, 3'd4, 3'd1, 3'd0, 5'b01000);
					3'd3: v = mk(3'd4, 3'd3, 3'd4, 3'd1, 3'd2, 3'd0, 5'b01100);
					3'd4: v = mk(3'd4, 3'd4, 3'd1, 3'd2, 3'd3, 3'd0, 5'b01110);
					default: v = mk(3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 5'b00000);
				endcase
			end
			3'd4: begin
				unique case (k)
					3'd0: v = mk(3'd4, 3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 5'b00000);
					3'd1: v = mk(3'd4, 3'd1, 3'd2, 3'd3, 3'd0, 3'd0, 5'b01000);
					3'd2: v = mk(3'd4, 3'd2, 3'd3, 3'd0, 3'd1, 3'd0, 5'b01100);
					3'd3: v = mk(3'd4, 3'd3, 3'd0, 3'd1, 3'd2, 3'd0, 5'b01110);
					3'd4: v = mk(3'd3, 3'd1, 3'd2, 3'd3, 3'd0, 3'd0, 5'b00000);
					3'd5: v = mk(3'd3, 3'd2, 3'd3, 3'd1, 3'd0, 3'd0, 5'b00100);
					3'd6: v = mk(3'd3, 3'd3, 3'd1, 3'd2, 3'd0, 3'd0, 5'b00110);
					default: v = mk(3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 5'b00000);
				endcase
			end
			3'd3: begin
				unique case (k)
					3'd0: v = mk(3'd3, 3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 5'b00000);
					3'd1: v = mk(3'd3, 3'd1, 3'd2, 3'd0, 3'd0, 3'd0, 5'b00100);
					3'd2: v = mk(3'd3, 3'd2, 3'd0, 3'd1, 3'd0, 3'd0, 5'b00110);
					default: v = mk(3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 5'b00000);
				endcase
			end
			default: v = mk(3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 5'b00000);
		endcase
		return v;
	endfunction

	function automatic logic [2:0] num_voicings(input logic [2:0] total);
		unique case (total)
			3'd5: return 3'd5;
			3'd4: return 3'd7;
			3'd3: return 3'd3;
			default: return 3'd0;
		endcase
	endfunction

	function automatic logic [1:0] type_class(input logic [4:0] t);
		unique case (t)
			5'd0, 5'd7, 5'd16, 5'd20: return 2'd0;
			5'd9, 5'd14, 5'd17: return 2'd1;
			default: return 2'd2;
		endcase
	endfunction

	// pitch class by compare and subtract of 192, 96, 48, 24 and 12
	function automatic logic [3:0] mod12(input logic [7:0] x);
		logic [7:0] r;
		r = x;
		if (r >= 8'd192) r = r - 8'd192;
		if (r >= 8'd96) r = r - 8'd96;
		if (r >= 8'd48) r = r - 8'd48;
		if (r >= 8'd24) r = r - 8'd24;
		if (r >= 8'd12) r = r - 8'd12;
		return r[3:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/hncr_match.sv =====
// Shared voicing matcher: gathers one voicing from the held notes, forms
// its intervals and looks them up in the chord pattern set. Uses hncr_pkg.
`default_nettype none
module hncr_match (
	input  wire logic [4:0][6:0]     notes,
	input  wire hncr_pkg::voicing_t  vc,
	output logic                     hit,
	output logic [4:0]               chord_type,
	output logic [3:0]               root
);
	logic [4:0][7:0] v;
	logic [7:0] b, c, d, e, lowp10;
	logic [2:0] n;

	always_comb begin
		for (int i = 0; i < hncr_pkg::MaxHeld; i++) begin
			v[i] = {1'b0, notes[vc.idx[i]]} + (vc.raise[i] ? 8'd12 : 8'd0);
		end
		// slots beyond the count read as zero
		if (vc.cnt < 3'd5) v[4] = 8'd0;
		if (vc.cnt < 3'd4) v[3] = 8'd0;
		n = vc.cnt;
		b = v[1] - v[0];
		c = v[2] - v[0];
		d = v[3] - v[0];
		e = v[4] - v[0];
		lowp10 = {1'b0, notes[0]} + 8'd10;
		hit = 1'b1;
		chord_type = 5'd0;
		priority if (n == 3'd5) begin
			priority if (e == 8'd14 && c == 8'd7) begin
				priority if (b == 8'd4 && d == 8'd10) chord_type = 5'd4;
				else if (b == 8'd4 && d == 8'd11) chord_type = 5'd6;
				else if (b == 8'd3 && d == 8'd10) chord_type = 5'd12;
				else hit = 1'b0;
			end else if (b == 8'd2 && d == 8'd7) begin
				priority if (c == 8'd4 && e == 8'd10) chord_type = 5'd4;
				else if (c == 8'd4 && e == 8'd11) chord_type = 5'd6;
				else if (c == 8'd3 && e == 8'd10) chord_type = 5'd12;
				else hit = 1'b0;
			end else if (b == 8'd3 && c == 8'd5 && d == 8'd7 && e == 8'd10)
				chord_type = 5'd15;
			else hit = 1'b0;
		end else if (n == 3'd4) begin
			priority if (c == 8'd7) begin
				priority if (d == 8'd9) begin
					priority if (b == 8'd4) chord_type = 5'd1;
					else if (b == 8'd3) chord_type = 5'd10;
					else hit = 1'b0;
				end else if (d == 8'd10) begin
					priority if (b == 8'd5) chord_type = 5'd8;
					else if (b == 8'd4) chord_type = 5'd2;
					else if (b == 8'd3) chord_type = 5'd11;
					else hit = 1'b0;
				end else if (d == 8'd14) begin
					priority if (b == 8'd4) chord_type = 5'd5;
					else if (b == 8'd3) chord_type = 5'd13;
					else hit = 1'b0;
				end else if (d == 8'd11 && b == 8'd4) chord_type = 5'd3;
				else hit = 1'b0;
			end else if (d == 8'd7) begin
				priority if (b == 8'd2) begin
					priority if (c == 8'd4) chord_type = (v[0] == lowp10) ? 5'd0 : 5'd5;
					else if (c == 8'd3) chord_type = (v[0] == lowp10) ? 5'd9 : 5'd13;
					else hit = 1'b0;
				end else if (b == 8'd3 && c == 8'd5) chord_type = 5'd14;
				else hit = 1'b0;
			end else if (d == 8'd9 && b == 8'd3 && c == 8'd6) chord_type = 5'd18;
			else if (d == 8'd10 && b == 8'd3 && c == 8'd6) chord_type = 5'd19;
			else hit = 1'b0;
		end else begin
			priority if (b == 8'd5 && c == 8'd7) chord_type = 5'd7;
			else if (b == 8'd4 && c == 8'd7) chord_type = 5'd0;
			else if (b == 8'd4 && c == 8'd8) chord_type = 5'd16;
			else if (b == 8'd3 && c == 8'd7) chord_type = 5'd9;
			else if (b == 8'd3 && c == 8'd6) chord_type = 5'd17;
			else if (b == 8'd7 && c == 8'd10) chord_type = 5'd21;
			else if (b == 8'd7 && c == 8'd12) chord_type = 5'd20;
			else if (b == 8'd4 && c == 8'd10) chord_type = 5'd2;
			else hit = 1'b0;
		end
		root = hncr_pkg::mod12(v[0]);
	end
endmodule
`default_nettype wire

// ===== hdl/held_note_chord_recognizer_core.sv =====
// Top level of the held-note chord recognizer: sorted note table, sequencer,
// one shared voicing matcher. Uses hncr_pkg and hncr_match.
// A note item takes one compare per held entry plus an end check, one shift
// step per moved entry plus the write, and a done state; a detect item takes
// one voicing per cycle through the shared matcher, up to seven, plus an end
// check and a done state. The result strobe comes in the same cycle that busy
// falls, when the next word may already be accepted; the receiver cannot stall.
// Reset clears count, changed mark, state, done strobe, pointer and dup flag.
`default_nettype none
module held_note_chord_recognizer_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire hncr_pkg::in_word_t  in_word,
	output logic                     busy,
	output logic                     done,
	output hncr_pkg::out_word_t      result
);
	hncr_pkg::state_t state_q, state_d;
	hncr_pkg::in_word_t item_q;
	logic [4:0][6:0] notes_q;
	logic [2:0] total_q;
	logic changed_q;
	logic [2:0] ptr_q;
	logic dup_q;
	hncr_pkg::out_word_t res_q;
	logic done_q;

	logic hit;
	logic [4:0] mtype;
	logic [3:0] mroot;
	hncr_pkg::voicing_t vc;

	assign vc = hncr_pkg::voicing(total_q, ptr_q);

	hncr_match u_match (
		.notes(notes_q), .vc(vc), .hit(hit), .chord_type(mtype), .root(mroot)
	);

	assign busy = (state_q != hncr_pkg::ST_IDLE);
	assign done = done_q;
	assign result = res_q;

	logic press;
	logic at_end;
	assign press = (item_q.velocity != 7'd0);
	assign at_end = (ptr_q == total_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hncr_pkg::ST_IDLE:
				if (start) state_d = (in_word.kind == hncr_pkg::KIND_DETECT)
					? hncr_pkg::ST_DETECT : hncr_pkg::ST_SCAN;
			hncr_pkg::ST_SCAN:
				if (at_end) state_d = hncr_pkg::ST_SHIFT;
				else if (!press && notes_q[ptr_q] == item_q.note) state_d = hncr_pkg::ST_SHIFT;
			hncr_pkg::ST_SHIFT: begin
				// insert walks down from the top, removal walks up from the hit
				if (press) begin
					if (dup_q || total_q == 3'd5 || ptr_q == 3'd0 ||
							item_q.note >= notes_q[ptr_q - 3'd1])
						state_d = hncr_pkg::ST_DONE;
				end else if (at_end || ptr_q + 3'd1 >= total_q)
					state_d = hncr_pkg::ST_DONE;
			end
			hncr_pkg::ST_DETECT:
				if (!changed_q || ptr_q >= hncr_pkg::num_voicings(total_q) || hit)
					state_d = hncr_pkg::ST_DONE;
			hncr_pkg::ST_DONE: state_d = hncr_pkg::ST_IDLE;
			default: state_d = hncr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hncr_pkg::ST_IDLE;
			total_q <= 3'd0;
			changed_q <= 1'b0;
			done_q <= 1'b0;
			ptr_q <= 3'd0;
			dup_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == hncr_pkg::ST_DONE);
			unique case (state_q)
				hncr_pkg::ST_IDLE: begin
					ptr_q <= 3'd0;
					dup_q <= 1'b0;
				end
				hncr_pkg::ST_SCAN: begin
					if (at_end) begin
						if (press) ptr_q <= ptr_q;
					end else if (notes_q[ptr_q] == item_q.note) begin
						if (press) dup_q <= 1'b1;
					end else ptr_q <= ptr_q + 3'd1;
					if (press && !at_end) begin
						if (notes_q[ptr_q] == item_q.note) ptr_q <= total_q;
						else ptr_q <= ptr_q + 3'd1;
					end
				end
				hncr_pkg::ST_SHIFT: begin
					if (press) begin
						if (!dup_q && total_q != 3'd5) begin
							if (ptr_q != 3'd0 && item_q.note < notes_q[ptr_q - 3'd1]) begin
								notes_q[ptr_q] <= notes_q[ptr_q - 3'd1];
								ptr_q <= ptr_q - 3'd1;
							end else begin
								notes_q[ptr_q] <= item_q.note;
								total_q <= total_q + 3'd1;
								changed_q <= 1'b1;
							end
						end
					end else if (!at_end) begin
						if (ptr_q + 3'd1 < total_q) begin
							notes_q[ptr_q] <= notes_q[ptr_q + 3'd1];
							ptr_q <= ptr_q + 3'd1;
						end else total_q <= total_q - 3'd1;
					end
				end
				hncr_pkg::ST_DETECT: begin
					if (state_d == hncr_pkg::ST_DONE) changed_q <= 1'b0;
					else ptr_q <= ptr_q + 3'd1;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == hncr_pkg::ST_IDLE && start) item_q <= in_word;
		if (state_q == hncr_pkg::ST_IDLE) res_q <= '0;
		if (state_q == hncr_pkg::ST_DETECT && changed_q && hit &&
				ptr_q < hncr_pkg::num_voicings(total_q)) begin
			res_q.matched <= 1'b1;
			res_q.root <= mroot;
			res_q.bass <= hncr_pkg::mod12({1'b0, notes_q[0]});
			res_q.chord_type <= mtype;
			res_q.chord_class <= hncr_pkg::type_class(mtype);
		end
		if (state_q == hncr_pkg::ST_DONE) res_q.held_count <= total_q;
	end
endmodule
`default_nettype wire
